/* rtl/sd_spi_init_and_block_read_macros.svh */
// ----------------------------------------------------------------------------
// SD SPI sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_INIT_AND_BLOCK_READ_MACROS_SVH
`define SD_SPI_INIT_AND_BLOCK_READ_MACROS_SVH

// check a condition at every edge
`define SDSPI_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// check that an antecedent is followed by a consequent on the next edge
`define SDSPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sdspi_pkg.sv */
// ----------------------------------------------------------------------------
// SD SPI sequencer package
// Types, codes, command frame constants and helpers shared by the block.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int BLOCK_BYTES_DEF = 512;

  localparam logic [15:0] TIMEOUT_RST = 16'd300;
  localparam logic [7:0]  TRIES_RST   = 8'd100;
  localparam logic [7:0]  WAKE_RST    = 8'd10;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] R1_LIMIT   = 8'h80;
  localparam logic [7:0] CMD_BASE   = 8'h40;
  localparam logic [2:0] FRAME_LEN  = 3'd6;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_TRIES   = 2'd1,
    REG_WAKE    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    FN_INIT = 2'd0,
    FN_READ = 2'd1,
    FN_XCHG = 2'd2,
    FN_TICK = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CMD0_BAD  = 3'd1,
    ST_CMD8_BAD  = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_CMD17_REJ = 3'd4,
    ST_TOKEN_TMO = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_WAKE      = 5'd1,
    PH_C0_SEND   = 5'd2,
    PH_C0_RESP   = 5'd3,
    PH_C0_GAP    = 5'd4,
    PH_C8_SEND   = 5'd5,
    PH_C8_RESP   = 5'd6,
    PH_C8_GAP    = 5'd7,
    PH_PRE55     = 5'd8,
    PH_C55_SEND  = 5'd9,
    PH_C55_RESP  = 5'd10,
    PH_MID       = 5'd11,
    PH_A41_SEND  = 5'd12,
    PH_A41_RESP  = 5'd13,
    PH_INIT_TAIL = 5'd14,
    PH_C17_SEND  = 5'd15,
    PH_C17_RESP  = 5'd16,
    PH_TOKEN     = 5'd17,
    PH_DATA      = 5'd18,
    PH_CRC       = 5'd19,
    PH_READ_TAIL = 5'd20
  } phase_e;

  typedef struct packed {
    logic [15:0] poll_limit;
    logic [7:0]  ready_tries;
    logic [7:0]  wake_bytes;
  } cfg_t;

  typedef struct packed {
    func_e       func;
    logic [31:0] card_addr;
    logic [9:0]  keep_count;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  tries_done;
    logic [15:0] poll_timer;
    logic [31:0] latched_address;
    logic [9:0]  latched_keep;
    logic        select_level;
  } state_t;

  typedef struct packed {
    status_e     status;
    logic        done_res;
    logic [8:0]  data_index;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        cs_level;
    logic [7:0]  tx_byte;
    logic        tx_valid;
  } result_t;

  // byte counter must hold the block size and any wake count
  function automatic int cnt_width(int bb);
    int w;
    w = $clog2(bb + 1);
    return (w > 8) ? w : 8;
  endfunction

  // one byte of a command frame: command, argument MSB first, CRC
  function automatic logic [7:0] frame_byte(phase_e ph, logic [2:0] k, logic [31:0] addr);
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    case (ph)
      PH_C0_SEND: begin
        cmd = 6'd0;  arg = 32'h0000_0000; crc = 8'h95;
      end
      PH_C8_SEND: begin
        cmd = 6'd8;  arg = 32'h0000_01AA; crc = 8'h87;
      end
      PH_C55_SEND: begin
        cmd = 6'd55; arg = 32'h0000_0000; crc = 8'h65;
      end
      PH_A41_SEND: begin
        cmd = 6'd41; arg = 32'h4000_0000; crc = 8'h77;
      end
      default: begin
        cmd = 6'd17; arg = addr;          crc = 8'h01;
      end
    endcase
    case (k)
      3'd0:    b = CMD_BASE | {2'b00, cmd};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

/* rtl/sd_spi_init_and_block_read.sv */
// ----------------------------------------------------------------------------
// SD card SPI-mode host sequencer, top level
// Card initialization and single-block read, one item per SPI byte or tick.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: each item is a command (tuser = start init or start read),
//   a finished byte exchange carrying the card's byte, or a millisecond tick.
//   Master channel: one result per item with the next byte to shift out, the
//   chip-select level, an optional forwarded block byte and done/status.
//   Configuration: cfg_we_i writes cfg_data_i to the register cfg_idx_i
//   (0 poll_limit, 1 ready_tries, 2 wake_bytes); write only while idle.
//   Throughput: one item per cycle while m_axis_tready takes each result. The
//   result register loads from the input register as the item advances,
//   with the step logic between the two registers.
//   Reset: sequencer idle, card deselected, registers at 300 / 100 / 10.
//   Stall: while a result waits on m_axis_tready the input register still
//   takes one more item; the slave side then holds tready low.
// ----------------------------------------------------------------------------
`include "sd_spi_init_and_block_read_macros.svh"

module sd_spi_init_and_block_read
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] card_addr, [41:32] keep_count, [49:42] rx_byte, [55:50] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] cs_level, [10] data_valid,
  // [18:11] data_byte, [27:19] data_index, [28] done_res, [31:29] status
  output logic [31:0] m_axis_tdata
);

  localparam int CntW = cnt_width(BLOCK_BYTES);

  cfg_t            cfg;
  item_t           item_q;
  logic            in_valid_q;
  logic            out_valid_q;
  result_t         res_q, res_d;
  state_t          st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            advance;
  logic            in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  sdspi_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  sdspi_step #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_step (
    .cfg_i  (cfg),
    .item_i (item_q),
    .st_i   (st_q),
    .cnt_i  (cnt_q),
    .st_o   (st_d),
    .cnt_o  (cnt_d),
    .res_o  (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{func:       func_e'(s_axis_tuser),
                  card_addr:  s_axis_tdata[31:0],
                  keep_count: s_axis_tdata[41:32],
                  rx_byte:    s_axis_tdata[49:42]};
    end
  end

  // sequencer state, updated as each item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{phase: PH_IDLE, tries_done: '0, poll_timer: '0,
                 latched_address: '0, latched_keep: '0, select_level: 1'b1};
      cnt_q <= '0;
    end else if (advance) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  `SDSPI_ASSERT(a_data_sends, !(out_valid_q && res_q.data_valid) || res_q.tx_valid, "data byte without a following exchange")
  `SDSPI_ASSERT(a_done_desel, !(out_valid_q && res_q.done_res) || res_q.cs_level, "operation finished with card selected")
  `SDSPI_ASSERT(a_status_done, !(out_valid_q && (res_q.status != ST_OK)) || res_q.done_res, "error status without done")
  `SDSPI_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q, "stalled item dropped from input register")

endmodule

/* rtl/sdspi_cfg.sv */
// ----------------------------------------------------------------------------
// SD SPI sequencer configuration registers
// Timeout, ready retry limit and wake byte count, written by index.
// ----------------------------------------------------------------------------
module sdspi_cfg
  import sdspi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [1:0]  idx_i,
  input  logic [15:0] data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        REG_TIMEOUT: cfg_d.poll_limit  = data_i;
        REG_TRIES:   cfg_d.ready_tries = data_i[7:0];
        REG_WAKE:    cfg_d.wake_bytes  = data_i[7:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{poll_limit: TIMEOUT_RST, ready_tries: TRIES_RST, wake_bytes: WAKE_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/sdspi_step.sv */
// ----------------------------------------------------------------------------
// SD SPI sequencer step logic
// Next state and result for one item given the current sequencer state.
// ----------------------------------------------------------------------------
module sdspi_step
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  cfg_t                                cfg_i,
  input  item_t                               item_i,
  input  state_t                              st_i,
  input  logic [cnt_width(BLOCK_BYTES)-1:0]   cnt_i,
  output state_t                              st_o,
  output logic [cnt_width(BLOCK_BYTES)-1:0]   cnt_o,
  output result_t                             res_o
);

  localparam int CntW = cnt_width(BLOCK_BYTES);
  localparam int CmpW = (CntW > 10) ? CntW : 10;

  state_t          nxt;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_inc;
  logic [7:0]      tries_inc;
  logic            tx_valid;
  logic [7:0]      tx_byte;
  logic            timed_out;
  logic            polling;
  result_t         res;

  assign cnt_inc   = cnt_i + CntW'(1);
  assign tries_inc = st_i.tries_done + 8'd1;
  assign timed_out = st_i.poll_timer >= cfg_i.poll_limit;
  assign polling   = (st_i.phase == PH_C0_RESP) || (st_i.phase == PH_C8_RESP) ||
                     (st_i.phase == PH_C55_RESP) || (st_i.phase == PH_A41_RESP) ||
                     (st_i.phase == PH_C17_RESP) || (st_i.phase == PH_TOKEN);

  always_comb begin
    nxt      = st_i;
    cnt      = cnt_i;
    tx_valid = 1'b0;
    tx_byte  = BYTE_IDLE;
    res      = '0;
    res.status = ST_OK;
    case (item_i.func)
      FN_INIT: begin
        nxt.phase        = PH_WAKE;
        nxt.select_level = 1'b1;
        nxt.tries_done   = '0;
        nxt.poll_timer   = '0;
        cnt              = CntW'(1);
        tx_valid         = 1'b1;
      end
      FN_READ: begin
        nxt.latched_address = item_i.card_addr;
        nxt.latched_keep    = item_i.keep_count;
        nxt.tries_done      = '0;
        nxt.poll_timer      = '0;
        nxt.phase           = PH_C17_SEND;
        nxt.select_level    = 1'b0;
        cnt                 = CntW'(1);
        tx_valid            = 1'b1;
        tx_byte             = frame_byte(PH_C17_SEND, 3'd0, item_i.card_addr);
      end
      FN_TICK: begin
        if (polling && (st_i.poll_timer != 16'hFFFF)) begin
          nxt.poll_timer = st_i.poll_timer + 16'd1;
        end
      end
      FN_XCHG: begin
        case (st_i.phase)
          PH_WAKE: begin
            tx_valid = 1'b1;
            if (cnt_i < CntW'(cfg_i.wake_bytes)) begin
              cnt = cnt_inc;
            end else begin
              nxt.phase        = PH_C0_SEND;
              nxt.select_level = 1'b0;
              cnt              = CntW'(1);
              tx_byte          = frame_byte(PH_C0_SEND, 3'd0, st_i.latched_address);
            end
          end
          PH_C0_SEND, PH_C8_SEND, PH_C55_SEND, PH_A41_SEND, PH_C17_SEND: begin
            tx_valid = 1'b1;
            if (cnt_i < CntW'(FRAME_LEN)) begin
              tx_byte = frame_byte(st_i.phase, cnt_i[2:0], st_i.latched_address);
              cnt     = cnt_inc;
            end else begin
              // response phase follows its send phase
              nxt.phase      = phase_e'(st_i.phase + 5'd1);
              nxt.poll_timer = '0;
            end
          end
          PH_C0_RESP, PH_C8_RESP, PH_C55_RESP, PH_A41_RESP, PH_C17_RESP: begin
            if ((item_i.rx_byte < R1_LIMIT) || timed_out) begin
              case (st_i.phase)
                PH_C0_RESP: begin
                  if (item_i.rx_byte == R1_IDLE) begin
                    nxt.phase = PH_C0_GAP; nxt.select_level = 1'b1; tx_valid = 1'b1;
                  end else begin
                    nxt.phase = PH_IDLE; nxt.select_level = 1'b1;
                    res.done_res = 1'b1; res.status = ST_CMD0_BAD;
                  end
                end
                PH_C8_RESP: begin
                  if (item_i.rx_byte == R1_IDLE) begin
                    nxt.phase = PH_C8_GAP; nxt.select_level = 1'b1; tx_valid = 1'b1;
                  end else begin
                    nxt.phase = PH_IDLE; nxt.select_level = 1'b1;
                    res.done_res = 1'b1; res.status = ST_CMD8_BAD;
                  end
                end
                PH_C55_RESP: begin
                  nxt.phase = PH_MID; tx_valid = 1'b1;
                end
                PH_A41_RESP: begin
                  nxt.tries_done = tries_inc;
                  if (item_i.rx_byte == R1_READY) begin
                    nxt.phase = PH_INIT_TAIL; nxt.select_level = 1'b1; tx_valid = 1'b1;
                  end else if (tries_inc >= cfg_i.ready_tries) begin
                    nxt.phase = PH_IDLE; nxt.select_level = 1'b1;
                    res.done_res = 1'b1; res.status = ST_NOT_READY;
                  end else begin
                    nxt.phase = PH_PRE55; nxt.select_level = 1'b0; tx_valid = 1'b1;
                  end
                end
                default: begin
                  if (item_i.rx_byte == R1_READY) begin
                    nxt.phase = PH_TOKEN; nxt.poll_timer = '0; tx_valid = 1'b1;
                  end else begin
                    nxt.phase = PH_IDLE; nxt.select_level = 1'b1;
                    res.done_res = 1'b1; res.status = ST_CMD17_REJ;
                  end
                end
              endcase
            end else begin
              tx_valid = 1'b1;
            end
          end
          PH_C0_GAP: begin
            nxt.phase = PH_C8_SEND; nxt.select_level = 1'b0; cnt = CntW'(1);
            tx_valid  = 1'b1;
            tx_byte   = frame_byte(PH_C8_SEND, 3'd0, st_i.latched_address);
          end
          PH_C8_GAP: begin
            nxt.tries_done = '0;
            nxt.phase = PH_PRE55; nxt.select_level = 1'b0; tx_valid = 1'b1;
          end
          PH_PRE55: begin
            nxt.phase = PH_C55_SEND; nxt.select_level = 1'b0; cnt = CntW'(1);
            tx_valid  = 1'b1;
            tx_byte   = frame_byte(PH_C55_SEND, 3'd0, st_i.latched_address);
          end
          PH_MID: begin
            nxt.phase = PH_A41_SEND; nxt.select_level = 1'b0; cnt = CntW'(1);
            tx_valid  = 1'b1;
            tx_byte   = frame_byte(PH_A41_SEND, 3'd0, st_i.latched_address);
          end
          PH_INIT_TAIL, PH_READ_TAIL: begin
            nxt.phase = PH_IDLE; nxt.select_level = 1'b1;
            res.done_res = 1'b1; res.status = ST_OK;
          end
          PH_TOKEN: begin
            if (item_i.rx_byte == TOKEN_DATA) begin
              nxt.phase = PH_DATA; cnt = '0; tx_valid = 1'b1;
            end else if (timed_out) begin
              nxt.phase = PH_IDLE; nxt.select_level = 1'b1;
              res.done_res = 1'b1; res.status = ST_TOKEN_TMO;
            end else begin
              tx_valid = 1'b1;
            end
          end
          PH_DATA: begin
            tx_valid = 1'b1;
            if (CmpW'(cnt_i) < CmpW'(st_i.latched_keep)) begin
              res.data_valid = 1'b1;
              res.data_byte  = item_i.rx_byte;
              res.data_index = 9'(cnt_i);
            end
            if (cnt_inc >= CntW'(BLOCK_BYTES)) begin
              nxt.phase = PH_CRC; cnt = '0;
            end else begin
              cnt = cnt_inc;
            end
          end
          PH_CRC: begin
            tx_valid = 1'b1;
            cnt      = cnt_inc;
            if (cnt_inc >= CntW'(2)) begin
              nxt.phase = PH_READ_TAIL; nxt.select_level = 1'b1;
            end
          end
          default: begin
            nxt = st_i;
          end
        endcase
      end
      default: begin
        nxt = st_i;
      end
    endcase
    res.tx_valid = tx_valid;
    res.tx_byte  = tx_byte;
    res.cs_level = nxt.select_level;
  end

  assign st_o  = nxt;
  assign cnt_o = cnt;
  assign res_o = res;

endmodule
